// ===== rtl/utf8_stream_decoder_defines.svh =====
// assertion macros for the checker file of the utf8 stream decoder
// expects clk and rst_n to be visible in the scope of each use
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define U8D_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8d same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define U8D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8d next-cycle check failed");

`endif

// ===== rtl/u8d_pkg.sv =====
// shared types and constants of the utf8 stream decoder
// no dependencies
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int BYTE_W     = 8;
  localparam int CP_W       = 21;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;

  localparam cp_t UNKNOWN_CP = cp_t'(63);

  // one decoded byte: some '?' results, then optionally one code point
  typedef struct packed {
    logic [1:0] nq;
    logic       has_cp;
    cp_t        cp;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/u8d_intf.sv =====
// channel interfaces of the utf8 stream decoder: byte input and code point output
// depends on u8d_pkg
`timescale 1ns / 1ps

interface u8d_byte_if;
  logic            valid;
  logic            ready;
  u8d_pkg::byte_t  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
  modport mon    (input valid, input ready, input in_byte);
endinterface

interface u8d_cp_if;
  logic          valid;
  logic          ready;
  u8d_pkg::cp_t  code_point;
  logic          last;

  modport source (output valid, output code_point, output last, input ready);
  modport sink   (input valid, input code_point, input last, output ready);
  modport mon    (input valid, input ready, input code_point, input last);
endinterface

// ===== rtl/utf8_stream_decoder.sv =====
// path: a byte's command goes into the queue, then into the back end's result register
// throughput: one byte per cycle while a byte gives at most one result and out_ch is ready;
// a byte with k results takes k output transfers, and a 4-command queue absorbs the bursts
// reset: synchronous active-low rst_n clears the open sequence, the queue and the output
// top level: front end, command queue, back end; depends on u8d_pkg, u8d_intf
`timescale 1ns / 1ps

module utf8_stream_decoder (
  input  logic      clk,
  input  logic      rst_n,
  u8d_byte_if.sink  in_ch,
  u8d_cp_if.source  out_ch
);
  import u8d_pkg::*;

  push_t      push;
  cmd_t       head;
  fifo_stat_t stat;
  logic       pop;

  u8d_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .push  (push)
  );

  u8d_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  u8d_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .stat   (stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/u8d_front.sv =====
// front end: accepts bytes, tracks the open sequence and classifies each byte
// into a command for the back end; depends on u8d_pkg and u8d_intf
`timescale 1ns / 1ps

module u8d_front (
  input  logic                clk,
  input  logic                rst_n,
  u8d_byte_if.sink            in_ch,
  input  u8d_pkg::fifo_stat_t stat,
  output u8d_pkg::push_t      push
);
  import u8d_pkg::*;

  logic [2:0] seq_r, seq_nxt;
  logic [1:0] held_r, held_nxt;
  cp_t        acc_r, acc_nxt;

  logic       acc_en;
  logic       is_cont;
  logic       do_lead;
  logic [2:0] rem;
  logic [2:0] held_inc;
  cp_t        addend;
  cp_t        acc_sum;
  byte_t      b;
  cmd_t       cmd;

  assign in_ch.ready = !stat.full;
  assign acc_en      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign is_cont     = (b[7:6] == 2'b10);
  assign rem         = seq_r - {1'b0, held_r} - 3'd1;
  assign held_inc    = {1'b0, held_r} + 3'd1;
  assign acc_sum     = acc_r | addend;

  always_comb begin
    case (rem[1:0])
      2'd0:    addend = {15'b0, b[5:0]};
      2'd1:    addend = {9'b0, b[5:0], 6'b0};
      2'd2:    addend = {3'b0, b[5:0], 12'b0};
      default: addend = {b[2:0], 18'b0};
    endcase
  end

  always_comb begin
    seq_nxt    = seq_r;
    held_nxt   = held_r;
    acc_nxt    = acc_r;
    cmd.nq     = 2'd0;
    cmd.has_cp = 1'b0;
    cmd.cp     = UNKNOWN_CP;
    do_lead    = 1'b1;

    if (seq_r != 3'd0) begin
      if (is_cont) begin
        do_lead = 1'b0;
        if (held_inc >= seq_r) begin
          cmd.has_cp = 1'b1;
          cmd.cp     = acc_sum;
          seq_nxt    = 3'd0;
          held_nxt   = 2'd0;
          acc_nxt    = '0;
        end else begin
          acc_nxt  = acc_sum;
          held_nxt = held_r + 2'd1;
        end
      end else begin
        // broken sequence: one '?' per held byte
        cmd.nq   = held_r;
        seq_nxt  = 3'd0;
        held_nxt = 2'd0;
        acc_nxt  = '0;
      end
    end

    if (do_lead) begin
      if (b == '0) begin
        // end of string, nothing for the zero byte itself
      end else if (b[7] == 1'b0) begin
        cmd.has_cp = 1'b1;
        cmd.cp     = {13'b0, b};
      end else if (b[7:5] == 3'b110) begin
        seq_nxt  = 3'd2;
        held_nxt = 2'd1;
        acc_nxt  = {10'b0, b[4:0], 6'b0};
      end else if (b[7:4] == 4'b1110) begin
        seq_nxt  = 3'd3;
        held_nxt = 2'd1;
        acc_nxt  = {5'b0, b[3:0], 12'b0};
      end else if (b[7:3] == 5'b11110) begin
        seq_nxt  = 3'd4;
        held_nxt = 2'd1;
        acc_nxt  = {b[2:0], 18'b0};
      end else begin
        cmd.has_cp = 1'b1;
        cmd.cp     = UNKNOWN_CP;
      end
    end
  end

  assign push.valid = acc_en && ((cmd.nq != 2'd0) || cmd.has_cp);
  assign push.cmd   = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= 3'd0;
      held_r <= 2'd0;
      acc_r  <= '0;
    end else if (acc_en) begin
      seq_r  <= seq_nxt;
      held_r <= held_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ===== rtl/u8d_cmd_fifo.sv =====
// small command queue between front and back end, flop based
// depends on u8d_pkg
`timescale 1ns / 1ps

module u8d_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  u8d_pkg::push_t      push,
  input  logic                pop,
  output u8d_pkg::cmd_t       head,
  output u8d_pkg::fifo_stat_t stat
);
  import u8d_pkg::*;

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + FIFO_CW'(do_push) - FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/u8d_back.sv =====
// back end: expands each command into result transactions from registers
// depends on u8d_pkg and u8d_intf
`timescale 1ns / 1ps

module u8d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  u8d_pkg::cmd_t       head,
  input  u8d_pkg::fifo_stat_t stat,
  output logic                pop,
  u8d_cp_if.source            out_ch
);
  import u8d_pkg::*;

  cmd_t       cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] qleft_r, qleft_nxt;
  logic       is_last;
  logic       out_acc;
  logic       load;

  assign is_last = (qleft_r == 2'd0) || ((qleft_r == 2'd1) && !cur_r.has_cp);
  assign out_acc = out_ch.valid && out_ch.ready;
  assign load    = !cur_valid_r || (out_acc && is_last);
  assign pop     = load && !stat.empty;

  assign out_ch.valid      = cur_valid_r;
  assign out_ch.code_point = (qleft_r != 2'd0) ? UNKNOWN_CP : cur_r.cp;
  assign out_ch.last       = is_last;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    qleft_nxt     = qleft_r;
    if (load) begin
      cur_nxt       = head;
      cur_valid_nxt = !stat.empty;
      qleft_nxt     = head.nq;
    end else if (out_acc) begin
      qleft_nxt = qleft_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      qleft_r     <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      qleft_r     <= qleft_nxt;
    end
  end

endmodule

// ===== rtl/u8d_checker.sv =====
// port-level checks of the utf8 stream decoder and their bind to the top level
// depends on u8d_pkg, u8d_intf and utf8_stream_decoder_defines.svh
`timescale 1ns / 1ps
`include "utf8_stream_decoder_defines.svh"

module u8d_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input u8d_pkg::cp_t out_code_point,
  input logic         out_last
);
  import u8d_pkg::*;

  logic [CP_W:0] out_word;

  assign out_word = {out_code_point, out_last};

  // a stalled result transaction keeps its payload
  `U8D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // only '?' results can precede the final result of a byte
  `U8D_ASSERT_IMPL(a_nonlast_unknown, out_valid && !out_last, out_code_point == UNKNOWN_CP)

  // right after reset the output is empty and a byte can be taken
  `U8D_ASSERT_IMPL(a_reset_idle, !$past(rst_n), !out_valid && in_ready)

endmodule

bind utf8_stream_decoder u8d_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_code_point (out_ch.code_point),
  .out_last       (out_ch.last)
);

// ===== bench/tb_utf8_stream_decoder.sv =====
// self-checking bench for utf8_stream_decoder: directed and random byte strings,
// randomly idled on both sides, results checked against an in-bench decoder
// depends on u8d_pkg, u8d_intf and the utf8_stream_decoder rtl
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
  import u8d_pkg::*;

  localparam int unsigned N_BYTES  = 370;
  localparam int unsigned DRAIN    = 8;

  typedef struct packed {
    cp_t  code_point;
    logic last;
  } cp_result_t;

  logic clk;
  logic rst_n;

  u8d_byte_if byte_ch ();
  u8d_cp_if   cp_ch ();

  utf8_stream_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (cp_ch)
  );

  byte_t        pending_bytes [$];
  cp_result_t   cp_expect [$];
  int unsigned  total_bytes    = 0;
  int unsigned  bytes_accepted = 0;
  int unsigned  mismatches     = 0;
  bit           byte_taken     = 1'b0;
  bit           hold_off       = 1'b0;
  int unsigned  send_gap = 0, send_calm = 0;
  int unsigned  recv_stall = 0, recv_calm = 0;

  // decoder state
  logic [2:0] seq_len;
  logic [2:0] held;
  cp_t        accum;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly no gap or a short one, a few long ones, and now and then a run with none
  function automatic int unsigned idle_len(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(20, 50);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic decode_byte(input byte_t b);
    cp_t        res [4];
    int         n;
    int         k;
    int         shift;
    bit         as_lead;
    cp_result_t item;
    n = 0;
    as_lead = 1'b1;
    if (seq_len != 0) begin
      if (b[7:6] == 2'b10 && held < seq_len) begin
        as_lead = 1'b0;
        shift = 6 * ((int'(seq_len) - int'(held) - 1) & 3);
        accum = accum | (cp_t'(b[5:0]) << shift);
        held = held + 3'd1;
        if (held >= seq_len) begin
          res[n] = accum;
          n++;
          seq_len = '0;
          held = '0;
          accum = '0;
        end
      end else begin
        for (k = 0; k < int'(held) && k < 3; k++) begin
          res[n] = UNKNOWN_CP;
          n++;
        end
        seq_len = '0;
        held = '0;
        accum = '0;
      end
    end
    if (as_lead && b != 8'h00) begin
      if (!b[7]) begin
        res[n] = cp_t'(b);
        n++;
      end else if (b[7:5] == 3'b110) begin
        seq_len = 3'd2;
        accum = cp_t'(b[4:0]) << 6;
        held = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
        seq_len = 3'd3;
        accum = cp_t'(b[3:0]) << 12;
        held = 3'd1;
      end else if (b[7:3] == 5'b11110) begin
        seq_len = 3'd4;
        accum = cp_t'(b[2:0]) << 18;
        held = 3'd1;
      end else begin
        res[n] = UNKNOWN_CP;
        n++;
      end
    end
    for (k = 0; k < n; k++) begin
      item.code_point = res[k];
      item.last = (k == n - 1);
      cp_expect.push_back(item);
    end
  endtask

  // driver: next byte or a gap once the current transaction has gone through
  always @(negedge clk) begin
    if (!rst_n) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (!byte_ch.valid || byte_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          byte_ch.in_byte <= pending_bytes.pop_front();
          byte_ch.valid <= 1'b1;
          send_gap = idle_len(send_calm);
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
      byte_taken = 1'b0;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      cp_ch.ready <= 1'b0;
    end else if (hold_off) begin
      cp_ch.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      cp_ch.ready <= 1'b0;
    end else begin
      cp_ch.ready <= 1'b1;
      recv_stall = idle_len(recv_calm);
    end
  end

  // monitor: predict on byte transactions, check result transactions
  always @(posedge clk) begin
    cp_result_t want;
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.in_byte);
        bytes_accepted++;
        byte_taken = 1'b1;
      end
      if (cp_ch.valid && cp_ch.ready) begin
        if (cp_expect.size() == 0) begin
          $error("unexpected result: code_point %0d last %0d", cp_ch.code_point, cp_ch.last);
          mismatches++;
        end else begin
          want = cp_expect.pop_front();
          if (cp_ch.code_point !== want.code_point) begin
            $error("code_point: expected %0d, got %0d", want.code_point, cp_ch.code_point);
            mismatches++;
          end
          if (cp_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, cp_ch.last);
            mismatches++;
          end
        end
      end
    end
  end

  // long receiver hold-offs so the queue fills and the input stalls
  initial begin
    while (bytes_accepted < 40) @(posedge clk);
    hold_off = 1'b1;
    repeat (60) @(posedge clk);
    hold_off = 1'b0;
    while (bytes_accepted < 200) @(posedge clk);
    hold_off = 1'b1;
    repeat (80) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    byte_t       directed [$];
    int unsigned sel;
    int unsigned len;
    int unsigned k;
    byte_t       b;
    seq_len = '0;
    held = '0;
    accum = '0;
    rst_n = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.in_byte = '0;
    cp_ch.ready = 1'b0;

    // zero with nothing open, ascii top, stray continuation, invalid leads,
    // complete 2/3/4 byte forms, broken sequences, four results, zero flush
    directed = '{8'h00, 8'h7f, 8'h80, 8'hf8, 8'hff,
                 8'hc2, 8'ha9, 8'he2, 8'h82, 8'hac,
                 8'hf7, 8'hbf, 8'hbf, 8'hbf,
                 8'he2, 8'h82, 8'hf4, 8'h8f, 8'hbf, 8'hbf,
                 8'hf0, 8'h90, 8'h80, 8'hff,
                 8'he1, 8'h00};
    foreach (directed[i]) pending_bytes.push_back(directed[i]);

    while (pending_bytes.size() < N_BYTES) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        pending_bytes.push_back(byte_t'($urandom_range(1, 127)));
      end else if (sel < 65 || sel >= 85) begin
        len = $urandom_range(2, 4);
        case (len)
          2: b = {3'b110, 5'($urandom)};
          3: b = {4'b1110, 4'($urandom)};
          default: b = {5'b11110, 3'($urandom)};
        endcase
        pending_bytes.push_back(b);
        if (sel < 65) begin
          for (k = 1; k < len; k++) pending_bytes.push_back({2'b10, 6'($urandom)});
        end else begin
          // broken: too few continuations, then a non-continuation byte
          for (k = $urandom_range(0, len - 2); k > 0; k--)
            pending_bytes.push_back({2'b10, 6'($urandom)});
          b = byte_t'($urandom_range(0, 255));
          while (b[7:6] == 2'b10) b = byte_t'($urandom_range(0, 255));
          pending_bytes.push_back(b);
        end
      end else if (sel < 75) begin
        pending_bytes.push_back(8'h00);
      end else begin
        pending_bytes.push_back(byte_t'($urandom_range(0, 255)));
      end
    end
    total_bytes = pending_bytes.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted < total_bytes) @(posedge clk);
    while (cp_expect.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/u8d_pkg.sv
rtl/u8d_intf.sv
rtl/u8d_front.sv
rtl/u8d_cmd_fifo.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder.sv
rtl/u8d_checker.sv
bench/tb_utf8_stream_decoder.sv
